// ===== design/cfpp_pkg.sv =====
// Shared types and constants of the closest/farthest point pair block.
// Used by the channel interfaces and all cfpp modules; depends on nothing.
package cfpp_pkg;

    localparam int COORD_W         = 16;
    localparam int IDX_W           = 4;
    localparam int SQ_W            = 34;
    localparam int DIST_W          = 26;
    localparam int FRAC_W          = 8;
    localparam int ROOT_W          = 25;
    localparam int KIND_W          = 2;
    localparam int DEF_MAX_POINTS  = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_FAR  = 2'd0,
        KIND_NEAR = 2'd1,
        KIND_FEW  = 2'd2
    } kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [SQ_W-1:0]           square_t;
    typedef logic [DIST_W-1:0]         dist_t;
    typedef logic [IDX_W-1:0]          idx_t;

endpackage

// ===== design/cfpp_if.sv =====
// Valid/ready channel interfaces for point items and result items.
// Depends on cfpp_pkg.
interface cfpp_point_if
    import cfpp_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface cfpp_result_if
    import cfpp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    idx_t              first_index;
    idx_t              second_index;
    dist_t             distance_fixed;
    logic              points_dropped;
    logic              last_result;

    modport source (output valid, result_kind, first_index, second_index, distance_fixed,
                    points_dropped, last_result, input ready);
    modport sink   (input valid, result_kind, first_index, second_index, distance_fixed,
                    points_dropped, last_result, output ready);
endinterface

// ===== design/closest_farthest_point_pair_core.sv =====
// Top level of the closest/farthest point pair block: loader, pair walker, output stage.
// Depends on cfpp_pkg, cfpp_if, cfpp_store and cfpp_isqrt.
//
// Usage: points arrive on the points channel, one item per point; the item with
// last_point set ends the set. Up to MAX_POINTS points are kept; later ones are
// dropped and points_dropped is set on every result of that set.
// Loading accepts one point per cycle. After the final point the block walks all
// pairs once to find the greatest and least squared distance, then walks them
// again for each distinct extreme, emitting matching pairs on the results channel:
// farthest pairs first, then closest pairs unless both distances are equal.
// Each pair visit passes through memory read, square, and sum and compare; each
// list is preceded by a square root. A set takes the scan walk plus one walk
// and one root per distinct extreme. Fewer than two points gives one too-few
// item. The last item of a set carries last_result. The points channel is ready
// only while loading. A stalled results channel holds the walk at the next match;
// the newest match waits in a holding register behind the output register.
// Reset clears the point count and all control state; no clearing pass is needed.
module closest_farthest_point_pair_core
    import cfpp_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic           clk,
    input  logic           rst_n,
    cfpp_point_if.sink     points,
    cfpp_result_if.source  results
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_FEW,
        S_RD,
        S_MUL,
        S_SUM,
        S_PUSH,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        M_SCAN,
        M_FAR,
        M_NEAR
    } mode_t;

    state_t  state_reg;
    mode_t   mode_reg;
    idx_t    cnt_reg;
    logic    ovf_reg;
    idx_t    i_reg;
    idx_t    j_reg;
    square_t great_reg;
    square_t least_reg;
    square_t target_reg;
    dist_t   dist_reg;
    square_t sqx_reg;
    square_t sqy_reg;

    logic    pend_valid_reg;
    kind_t   pend_kind_reg;
    idx_t    pend_i_reg;
    idx_t    pend_j_reg;
    dist_t   pend_dist_reg;

    logic               out_valid_reg;
    logic [KIND_W-1:0]  out_kind_reg;
    idx_t               out_i_reg;
    idx_t               out_j_reg;
    dist_t              out_dist_reg;
    logic               out_drop_reg;
    logic               out_last_reg;

    logic                 in_fire;
    logic                 has_room;
    idx_t                 cnt_after;
    logic                 out_free;
    logic                 out_load;
    logic                 last_pair;
    logic [2*COORD_W-1:0] rd_a;
    logic [2*COORD_W-1:0] rd_b;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [SQ_W-1:0]  dx_sq;
    logic signed [SQ_W-1:0]  dy_sq;
    square_t              pair_sq;
    logic                 sq_start;
    logic                 sq_done;
    dist_t                sq_root;

    assign in_fire   = points.valid && points.ready;
    assign has_room  = cnt_reg < IDX_W'(MAX_POINTS);
    assign cnt_after = has_room ? cnt_reg + 1'b1 : cnt_reg;
    assign out_free  = !out_valid_reg || results.ready;
    assign out_load  = out_free && ((state_reg == S_FEW) || (state_reg == S_FLUSH)
                                    || (state_reg == S_PUSH && pend_valid_reg));
    assign last_pair = (j_reg + 1'b1 >= cnt_reg) && (i_reg + 2'd2 >= cnt_reg);

    cfpp_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .clk       (clk),
        .wr_en     (in_fire && has_room),
        .wr_addr   (cnt_reg[AW-1:0]),
        .wr_data   ({points.point_x, points.point_y}),
        .rd_addr_a (i_reg[AW-1:0]),
        .rd_addr_b (j_reg[AW-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    assign dx      = $signed({rd_b[2*COORD_W-1], rd_b[2*COORD_W-1 -: COORD_W]})
                   - $signed({rd_a[2*COORD_W-1], rd_a[2*COORD_W-1 -: COORD_W]});
    assign dy      = $signed({rd_b[COORD_W-1], rd_b[COORD_W-1:0]})
                   - $signed({rd_a[COORD_W-1], rd_a[COORD_W-1:0]});
    assign dx_sq   = dx * dx;
    assign dy_sq   = dy * dy;
    assign pair_sq = sqx_reg + sqy_reg;
    assign sq_start = (state_reg == S_ROOT_GO);

    cfpp_isqrt u_isqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sq_start),
        .square (target_reg),
        .done   (sq_done),
        .root   (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            mode_reg       <= M_SCAN;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            great_reg      <= '0;
            least_reg      <= '1;
            target_reg     <= '0;
            dist_reg       <= '0;
            sqx_reg        <= '0;
            sqy_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_kind_reg  <= KIND_FAR;
            pend_i_reg     <= '0;
            pend_j_reg     <= '0;
            pend_dist_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= KIND_FAR;
            out_i_reg      <= '0;
            out_j_reg      <= '0;
            out_dist_reg   <= '0;
            out_drop_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && results.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        cnt_reg <= cnt_after;
                        if (!has_room)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (points.last_point)
                        begin
                            if (cnt_after < 2'd2)
                            begin
                                state_reg <= S_FEW;
                            end
                            else
                            begin
                                great_reg <= '0;
                                least_reg <= '1;
                                mode_reg  <= M_SCAN;
                                i_reg     <= '0;
                                j_reg     <= idx_t'(1);
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_FEW:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_kind_reg  <= KIND_FEW;
                        out_i_reg     <= '0;
                        out_j_reg     <= '0;
                        out_dist_reg  <= '0;
                        out_drop_reg  <= ovf_reg;
                        out_last_reg  <= 1'b1;
                        cnt_reg       <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= S_LOAD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    sqx_reg   <= square_t'(dx_sq);
                    sqy_reg   <= square_t'(dy_sq);
                    state_reg <= S_SUM;
                end
                S_SUM, S_PUSH:
                begin
                    if (state_reg == S_SUM && mode_reg == M_SCAN)
                    begin
                        if (pair_sq > great_reg)
                        begin
                            great_reg <= pair_sq;
                        end
                        if (pair_sq < least_reg)
                        begin
                            least_reg <= pair_sq;
                        end
                    end
                    if (state_reg == S_SUM && mode_reg != M_SCAN && pair_sq == target_reg)
                    begin
                        state_reg <= S_PUSH;
                    end
                    else if (state_reg == S_PUSH && !out_free)
                    begin
                        state_reg <= S_PUSH;
                    end
                    else
                    begin
                        if (state_reg == S_PUSH)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_kind_reg  <= pend_kind_reg;
                                out_i_reg     <= pend_i_reg;
                                out_j_reg     <= pend_j_reg;
                                out_dist_reg  <= pend_dist_reg;
                                out_drop_reg  <= ovf_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_kind_reg  <= (mode_reg == M_FAR) ? KIND_FAR : KIND_NEAR;
                            pend_i_reg     <= i_reg;
                            pend_j_reg     <= j_reg;
                            pend_dist_reg  <= dist_reg;
                        end
                        if (!last_pair)
                        begin
                            if (j_reg + 1'b1 < cnt_reg)
                            begin
                                j_reg <= j_reg + 1'b1;
                            end
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                                j_reg <= i_reg + 2'd2;
                            end
                            state_reg <= S_RD;
                        end
                        else
                        begin
                            case (mode_reg)
                                M_SCAN:
                                begin
                                    mode_reg   <= M_FAR;
                                    target_reg <= (pair_sq > great_reg) ? pair_sq : great_reg;
                                    state_reg  <= S_ROOT_GO;
                                end
                                M_FAR:
                                begin
                                    if (least_reg != great_reg)
                                    begin
                                        mode_reg   <= M_NEAR;
                                        target_reg <= least_reg;
                                        state_reg  <= S_ROOT_GO;
                                    end
                                    else
                                    begin
                                        state_reg <= S_FLUSH;
                                    end
                                end
                                default:
                                begin
                                    state_reg <= S_FLUSH;
                                end
                            endcase
                        end
                    end
                end
                S_ROOT_GO:
                begin
                    if (mode_reg == M_FAR && target_reg != great_reg)
                    begin
                        target_reg <= great_reg;
                    end
                    else
                    begin
                        state_reg <= S_ROOT_WAIT;
                    end
                end
                S_ROOT_WAIT:
                begin
                    if (sq_done)
                    begin
                        dist_reg  <= sq_root;
                        i_reg     <= '0;
                        j_reg     <= idx_t'(1);
                        state_reg <= S_RD;
                    end
                end
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= pend_kind_reg;
                        out_i_reg      <= pend_i_reg;
                        out_j_reg      <= pend_j_reg;
                        out_dist_reg   <= pend_dist_reg;
                        out_drop_reg   <= ovf_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        cnt_reg        <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign points.ready           = (state_reg == S_LOAD);
    assign results.valid          = out_valid_reg;
    assign results.result_kind    = out_kind_reg;
    assign results.first_index    = out_i_reg;
    assign results.second_index   = out_j_reg;
    assign results.distance_fixed = out_dist_reg;
    assign results.points_dropped = out_drop_reg;
    assign results.last_result    = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= IDX_W'(MAX_POINTS))
        else $error("point count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != M_SCAN && state_reg == S_RD) |-> great_reg >= least_reg)
        else $error("least distance above greatest");
    assert property (@(posedge clk) disable iff (!rst_n) sq_done |-> state_reg == S_ROOT_WAIT)
        else $error("root finished outside wait");
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.last_result) |-> !pend_valid_reg)
        else $error("last item sent with a match still held");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (i_reg < j_reg && j_reg < cnt_reg))
        else $error("pair walk out of range");

endmodule

// ===== design/cfpp_store.sv =====
// Point memory: one write port, two read ports, registered read data.
// Depends on cfpp_pkg.
module cfpp_store
    import cfpp_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_POINTS,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [2*COORD_W-1:0]  wr_data,
    input  logic [AW-1:0]         rd_addr_a,
    input  logic [AW-1:0]         rd_addr_b,
    output logic [2*COORD_W-1:0]  rd_data_a,
    output logic [2*COORD_W-1:0]  rd_data_b
);

    logic [2*COORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== design/cfpp_isqrt.sv =====
// Digit-by-digit integer square root of (square << FRAC_W*2), one root bit per cycle.
// Depends on cfpp_pkg.
module cfpp_isqrt
    import cfpp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  square_t square,
    output logic    done,
    output dist_t   root
);

    localparam int N_W   = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 3;

    logic [N_W-1:0]            n_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [$clog2(ROOT_W)-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_shift = {rem_reg[REM_W-3:0], n_reg[N_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = rem_shift >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(ROOT_W))'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg    <= {square, (N_W - SQ_W)'(0)};
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            n_reg <= {n_reg[N_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = DIST_W'(root_reg);

    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("isqrt did not start");
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("isqrt done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !start)
        else $error("isqrt restarted while busy");

endmodule
